### hw/rtl/csma_backoff_arq_transmitter_unit_macros.svh
// Assertion shorthands used by the checker file of this block.
`ifndef CSMA_BACKOFF_ARQ_TRANSMITTER_UNIT_MACROS_SVH
`define CSMA_BACKOFF_ARQ_TRANSMITTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while arst_n is low.
`define CBAT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbat assertion failed");

// Next-cycle implication, sampled on clk and ignored while arst_n is low.
`define CBAT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbat assertion failed");

`endif

### hw/rtl/cbat_pkg.sv
package cbat_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int TICK_W          = 16;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 16;

	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd10;
	localparam logic [3:0]  MAX_RETRIES_RST = 4'd3;
	localparam logic [30:0] LCG_SEED_RST    = 31'd12345;
	localparam logic [30:0] LCG_MUL         = 31'd1103515245;
	localparam logic [30:0] LCG_INC         = 31'd12345;

	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 1'd1;

	localparam logic [2:0] FN_TICK   = 3'd0;
	localparam logic [2:0] FN_SUBMIT = 3'd1;
	localparam logic [2:0] FN_BUSY   = 3'd2;
	localparam logic [2:0] FN_IDLE   = 3'd3;
	localparam logic [2:0] FN_ACK    = 3'd4;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_WAIT    = 2'd1,
		PH_BACKOFF = 2'd2,
		PH_ACK     = 2'd3
	} phase_t;

	typedef struct packed {
		logic [2:0]        func;
		logic [TICK_W-1:0] tick_ms;
		logic              needs_ack;
		logic [7:0]        frame_seq;
		logic [7:0]        ack_seq;
	} evt_item_t;

	typedef struct packed {
		logic       send_now;
		logic       frame_taken;
		logic       ack_matched;
		logic       gave_up;
		logic [1:0] tx_phase;
		logic       pending;
		logic       busy_seen;
		logic [3:0] retry_count;
	} res_item_t;

	// One step of the generator; the 31-bit product wraps modulo 2^31 by width.
	function automatic logic [30:0] lcg_next(input logic [30:0] s);
		lcg_next = s * LCG_MUL + LCG_INC;
	endfunction

	// Backoff of 1 to 10 from a seed. Since 16 is 1 modulo 5, the nibble sum keeps the
	// residue modulo 5; the parity bit then picks between r + 1 and r + 6.
	function automatic logic [3:0] backoff_of(input logic [30:0] s);
		logic [6:0] sum;
		logic [4:0] fold;
		logic [2:0] r;
		sum = 7'(s[3:0]) + 7'(s[7:4]) + 7'(s[11:8]) + 7'(s[15:12])
		    + 7'(s[19:16]) + 7'(s[23:20]) + 7'(s[27:24]) + 7'(s[30:28]);
		fold = 5'(sum[6:4]) + 5'(sum[3:0]);
		if (fold >= 5'd20) begin
			r = 3'(fold - 5'd20);
		end else if (fold >= 5'd15) begin
			r = 3'(fold - 5'd15);
		end else if (fold >= 5'd10) begin
			r = 3'(fold - 5'd10);
		end else if (fold >= 5'd5) begin
			r = 3'(fold - 5'd5);
		end else begin
			r = 3'(fold);
		end
		if (r[0] == s[0]) begin
			backoff_of = 4'(r) + 4'd1;
		end else begin
			backoff_of = 4'(r) + 4'd6;
		end
	endfunction

endpackage

### hw/rtl/csma_backoff_arq_transmitter_unit.sv
// Transmit controller for a shared medium, one frame held at a time.
// Events enter on evt (evt_valid/evt_ready): ticks, frame submits, medium busy and
// idle reports, and received acknowledgements. Every event yields exactly one status
// transaction on res (res_valid/res_ready) with the pulses it caused and the state
// after it.
// From acceptance to res_valid an event passes an input register, then the state update
// and result register. Throughput is one event per cycle while res is not stalled;
// the state registers close their loop through a single level of compare and subtract.
// The backoff generator runs two stages ahead of its use: the next seed and its
// backoff are recomputed continuously from the current seed, which suffices since
// two draws are always at least three events apart.
// While res is stalled the result register holds and the input register can still
// take one more event; evt_ready then falls until res is taken.
// Reset clears the phase, held flag, countdown, retry count and busy flag, restores both
// configuration registers and reseeds the generator. Configuration writes on
// cfg_we take effect at once and are meant for idle periods only.
module csma_backoff_arq_transmitter_unit
	import cbat_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  evt_valid,
	output logic                  evt_ready,
	input  evt_item_t             evt,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_item_t             res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CMP_W = (TIMER_WIDTH > TICK_W) ? TIMER_WIDTH : TICK_W;

	logic             evt_valid_s1;
	evt_item_t        evt_s1;
	logic             res_valid_q;
	res_item_t        res_q;
	res_item_t        res_d;
	logic             advance;
	logic             fire;

	logic [15:0]      ack_timeout_q;
	logic [3:0]       max_retries_q;

	phase_t           phase_q, phase_d;
	logic             held_q, held_d;
	logic             held_needs_ack_q;
	logic [7:0]       held_seq_q;
	logic [TIMER_WIDTH-1:0] countdown_q, countdown_d;
	logic [3:0]       retries_q, retries_d;
	logic             busy_q, busy_d;
	logic [30:0]      seed_q;
	logic             draw;
	logic             store_frame;

	logic [30:0]      nseed_s1;
	logic [3:0]       nback_s2;

	logic             is_tick;
	logic             expired;
	logic [TIMER_WIDTH-1:0] remaining;
	logic             can_retry;
	logic             ack_hit;

	assign advance   = !res_valid_q || res_ready;
	assign fire      = evt_valid_s1 && advance;
	assign evt_ready = !evt_valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign is_tick   = (evt_s1.func == FN_TICK);
	assign expired   = CMP_W'(countdown_q) <= CMP_W'(evt_s1.tick_ms);
	assign remaining = TIMER_WIDTH'(CMP_W'(countdown_q) - CMP_W'(evt_s1.tick_ms));
	assign can_retry = retries_q < max_retries_q;
	assign ack_hit   = (phase_q == PH_ACK) && (held_seq_q == evt_s1.ack_seq);

	always_comb begin
		phase_d     = phase_q;
		held_d      = held_q;
		countdown_d = countdown_q;
		retries_d   = retries_q;
		busy_d      = busy_q;
		draw        = 1'b0;
		store_frame = 1'b0;
		unique case (evt_s1.func)
			FN_TICK: begin
				unique case (phase_q)
					PH_IDLE: begin
						if (held_q) begin
							phase_d   = PH_WAIT;
							retries_d = '0;
						end
					end
					PH_WAIT: begin
						if (!busy_q) begin
							draw        = 1'b1;
							countdown_d = TIMER_WIDTH'(nback_s2);
							phase_d     = PH_BACKOFF;
						end
					end
					PH_BACKOFF: begin
						if (busy_q) begin
							phase_d = PH_WAIT;
						end else if (expired) begin
							if (held_needs_ack_q) begin
								countdown_d = TIMER_WIDTH'(ack_timeout_q);
								phase_d     = PH_ACK;
							end else begin
								countdown_d = '0;
								held_d      = 1'b0;
								phase_d     = PH_IDLE;
							end
						end else begin
							countdown_d = remaining;
						end
					end
					PH_ACK: begin
						if (expired) begin
							if (can_retry) begin
								retries_d = retries_q + 4'd1;
								phase_d   = PH_WAIT;
							end else begin
								held_d  = 1'b0;
								phase_d = PH_IDLE;
							end
						end else begin
							countdown_d = remaining;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
			FN_SUBMIT: begin
				if (!held_q) begin
					store_frame = 1'b1;
					held_d      = 1'b1;
				end
			end
			FN_BUSY: busy_d = 1'b1;
			FN_IDLE: busy_d = 1'b0;
			FN_ACK: begin
				if (ack_hit) begin
					held_d  = 1'b0;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				busy_d = busy_q;
			end
		endcase
	end

	always_comb begin
		res_d             = '0;
		res_d.send_now    = is_tick && (phase_q == PH_BACKOFF) && !busy_q && expired;
		res_d.frame_taken = (evt_s1.func == FN_SUBMIT) && !held_q;
		res_d.ack_matched = (evt_s1.func == FN_ACK) && ack_hit;
		res_d.gave_up     = is_tick && (phase_q == PH_ACK) && expired && !can_retry;
		res_d.tx_phase    = phase_d;
		res_d.pending     = held_d;
		res_d.busy_seen   = busy_d;
		res_d.retry_count = retries_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (evt_ready) begin
				evt_valid_s1 <= evt_valid;
			end
			if (advance) begin
				res_valid_q <= evt_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			evt_s1 <= evt;
		end
		if (fire) begin
			res_q <= res_d;
		end
		if (fire && store_frame) begin
			held_needs_ack_q <= evt_s1.needs_ack;
			held_seq_q       <= evt_s1.frame_seq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= ACK_TIMEOUT_RST;
			max_retries_q <= MAX_RETRIES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
				CFG_MAX_RETRIES: max_retries_q <= cfg_data[3:0];
				default: begin
					ack_timeout_q <= ack_timeout_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			held_q      <= 1'b0;
			countdown_q <= '0;
			retries_q   <= '0;
			busy_q      <= 1'b0;
			seed_q      <= LCG_SEED_RST;
		end else if (fire) begin
			phase_q     <= phase_d;
			held_q      <= held_d;
			countdown_q <= countdown_d;
			retries_q   <= retries_d;
			busy_q      <= busy_d;
			if (draw) begin
				seed_q <= nseed_s1;
			end
		end
	end

	// Look-ahead for the generator: the multiply and the modulo sit in separate stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nseed_s1 <= lcg_next(LCG_SEED_RST);
			nback_s2 <= backoff_of(lcg_next(LCG_SEED_RST));
		end else begin
			nseed_s1 <= lcg_next(seed_q);
			nback_s2 <= backoff_of(nseed_s1);
		end
	end

endmodule

### hw/rtl/cbat_checker.sv
`include "csma_backoff_arq_transmitter_unit_macros.svh"

module cbat_checker
	import cbat_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res
);

	// A stalled status transaction stays offered and unchanged.
	`CBAT_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

	// An accepted submit always leaves a frame held.
	`CBAT_ASSERT_IMP(a_taken_pending, res_valid && res.frame_taken, res.pending)

	// Completion and dropping both release the frame and return to idle.
	`CBAT_ASSERT_IMP(a_done_idle, res_valid && (res.ack_matched || res.gave_up),
		!res.pending && (res.tx_phase == PH_IDLE))

	// A send ends either in the acknowledgement wait or, without one, back in idle.
	`CBAT_ASSERT_IMP(a_send_phase, res_valid && res.send_now,
		(res.pending && (res.tx_phase == PH_ACK)) || (!res.pending && (res.tx_phase == PH_IDLE)))

	// Without a held frame the controller can only be idle.
	`CBAT_ASSERT_IMP(a_idle_when_empty, res_valid && !res.pending, res.tx_phase == PH_IDLE)

endmodule

bind csma_backoff_arq_transmitter_unit cbat_checker u_cbat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
